[rtl/core/safg_pkg.sv]
// Package for the synthetic audio frame generator core.
// Holds stream geometry, LFSR and tone constants, and shared item types.
// No dependencies.
package safg_pkg;

   // Stream geometry
   localparam int FRAME_BYTES = 40;
   localparam int FRAME_COUNT = 500;

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int FRAME_W = 9;
   localparam int POS_W   = 6;
   localparam int SUM_W   = 32;
   localparam int LFSR_W  = 32;
   localparam int GI_W    = 15;

   // Channel widths (tdata padded to whole bytes)
   localparam int REQ_DATA_W = 8;
   localparam int RSP_BITS   = BYTE_W + FRAME_W + POS_W + SUM_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // LFSR constants
   localparam logic [LFSR_W-1:0] LFSR_TAPS  = 32'hD000_0001;
   localparam logic [LFSR_W-1:0] SEED_RESET = 32'h1ACE_B00C;

   // Byte codes
   localparam logic [BYTE_W-1:0] MARKER_BYTE = 8'hF8;
   localparam logic [BYTE_W-1:0] TONE_HIGH   = 8'hC0;
   localparam logic [BYTE_W-1:0] TONE_LOW    = 8'h40;
   localparam int                NOISE_W     = 6;

   // Tone phase: index * PHASE_NUM / PHASE_DEN, tracked as quotient and remainder
   localparam int PHASE_NUM  = 440 * 256;
   localparam int PHASE_DEN  = 16000;
   localparam int PHASE_INT  = PHASE_NUM / PHASE_DEN;
   localparam int PHASE_FRAC = PHASE_NUM % PHASE_DEN;
   localparam int PHASE_Q_W  = 8;
   localparam int PHASE_R_W  = $clog2(PHASE_DEN);
   localparam int TONE_BIT   = 7;

   // One generated result item
   typedef struct packed {
      logic                 last_byte;
      logic [SUM_W-1:0]     running_checksum;
      logic [POS_W-1:0]     byte_in_frame;
      logic [FRAME_W-1:0]   frame_number;
      logic [BYTE_W-1:0]    data_byte;
   } result_type;

   // Control from the input stage to the generator
   typedef struct packed {
      logic step;
      logic restart;
   } step_type;

   // One Galois LFSR step: shift right, fold the taps in when a one drops out
   function automatic logic [LFSR_W-1:0] lfsr_advance(input logic [LFSR_W-1:0] v);
      logic [LFSR_W-1:0] s;
      s = v >> 1;
      if (v[0]) begin
         s = s ^ LFSR_TAPS;
      end
      return s;
   endfunction

endpackage

[rtl/core/safg_engine.sv]
// Stream state and next-byte logic of the frame generator.
// Depends on safg_pkg.
module safg_engine (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [safg_pkg::LFSR_W-1:0] csr_wr_data,
   input  safg_pkg::step_type         ctrl,
   output logic                       has_result,
   output safg_pkg::result_type       result
);
   import safg_pkg::*;

   logic [LFSR_W-1:0]    seed_ff, seed_in;
   logic [LFSR_W-1:0]    lfsr_ff, lfsr_in;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [GI_W-1:0]      gi_ff, gi_in;
   logic [PHASE_Q_W-1:0] phq_ff, phq_in;
   logic [PHASE_R_W-1:0] phr_ff, phr_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic                 fin_ff, fin_in;

   // State as seen by the current item (a restart first clears it and loads the LFSR from the seed)
   logic [LFSR_W-1:0]    lfsr_eff;
   logic [FRAME_W-1:0]   frame_eff;
   logic [POS_W-1:0]     pos_eff;
   logic [GI_W-1:0]      gi_eff;
   logic [PHASE_Q_W-1:0] phq_eff;
   logic [PHASE_R_W-1:0] phr_eff;
   logic [SUM_W-1:0]     sum_eff;
   logic                 fin_eff;

   logic [LFSR_W-1:0]    lfsr_step;
   logic [BYTE_W-1:0]    tone;
   logic [BYTE_W-1:0]    byte_val;
   logic                 is_payload;
   logic                 is_last;
   logic [SUM_W-1:0]     sum_new;
   logic [PHASE_R_W:0]   phr_sum;

   // Seed register
   assign seed_in = csr_wr_en ? csr_wr_data : seed_ff;

   // Effective state after an optional restart
   always_comb begin
      if (ctrl.restart) begin
         lfsr_eff  = seed_ff;
         frame_eff = '0;
         pos_eff   = '0;
         gi_eff    = '0;
         phq_eff   = '0;
         phr_eff   = '0;
         sum_eff   = '0;
         fin_eff   = 1'b0;
      end else begin
         lfsr_eff  = lfsr_ff;
         frame_eff = frame_ff;
         pos_eff   = pos_ff;
         gi_eff    = gi_ff;
         phq_eff   = phq_ff;
         phr_eff   = phr_ff;
         sum_eff   = sum_ff;
         fin_eff   = fin_ff;
      end
   end

   // Byte selection: marker, frame index, or tone xor noise
   assign lfsr_step  = lfsr_advance(lfsr_eff);
   assign tone       = phq_eff[TONE_BIT] ? TONE_HIGH : TONE_LOW;
   assign is_payload = (pos_eff != POS_W'(0)) && (pos_eff != POS_W'(1));

   always_comb begin
      priority if (pos_eff == POS_W'(0)) begin
         byte_val = MARKER_BYTE;
      end else if (pos_eff == POS_W'(1)) begin
         byte_val = frame_eff[BYTE_W-1:0];
      end else begin
         byte_val = tone ^ {{(BYTE_W-NOISE_W){1'b0}}, lfsr_step[NOISE_W-1:0]};
      end
   end

   assign sum_new = sum_eff + {{(SUM_W-BYTE_W){1'b0}}, byte_val};
   assign is_last = (frame_eff == FRAME_W'(FRAME_COUNT - 1)) &&
                    (pos_eff == POS_W'(FRAME_BYTES - 1));

   assign has_result                = ctrl.step && !fin_eff;
   assign result.data_byte          = byte_val;
   assign result.frame_number       = frame_eff;
   assign result.byte_in_frame      = pos_eff;
   assign result.running_checksum   = sum_new;
   assign result.last_byte          = is_last;

   assign phr_sum = {1'b0, phr_eff} + (PHASE_R_W+1)'(PHASE_FRAC);

   // Next state: only an item that yields a byte moves the stream on
   always_comb begin
      lfsr_in  = lfsr_ff;
      frame_in = frame_ff;
      pos_in   = pos_ff;
      gi_in    = gi_ff;
      phq_in   = phq_ff;
      phr_in   = phr_ff;
      sum_in   = sum_ff;
      fin_in   = fin_ff;
      if (has_result) begin
         lfsr_in = is_payload ? lfsr_step : lfsr_eff;
         sum_in  = sum_new;
         fin_in  = is_last;
         frame_in = frame_eff;
         pos_in   = pos_eff;
         if (!is_last) begin
            if (pos_eff == POS_W'(FRAME_BYTES - 1)) begin
               pos_in   = '0;
               frame_in = frame_eff + FRAME_W'(1);
            end else begin
               pos_in = pos_eff + POS_W'(1);
            end
         end
         // Running index and its tone phase wrap together
         if (gi_eff == {GI_W{1'b1}}) begin
            gi_in  = '0;
            phq_in = '0;
            phr_in = '0;
         end else begin
            gi_in = gi_eff + GI_W'(1);
            if (phr_sum >= (PHASE_R_W+1)'(PHASE_DEN)) begin
               phr_in = PHASE_R_W'(phr_sum - (PHASE_R_W+1)'(PHASE_DEN));
               phq_in = phq_eff + PHASE_Q_W'(PHASE_INT + 1);
            end else begin
               phr_in = phr_sum[PHASE_R_W-1:0];
               phq_in = phq_eff + PHASE_Q_W'(PHASE_INT);
            end
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= SEED_RESET;
         lfsr_ff  <= SEED_RESET;
         frame_ff <= '0;
         pos_ff   <= '0;
         gi_ff    <= '0;
         phq_ff   <= '0;
         phr_ff   <= '0;
         sum_ff   <= '0;
         fin_ff   <= 1'b0;
      end else begin
         seed_ff  <= seed_in;
         lfsr_ff  <= lfsr_in;
         frame_ff <= frame_in;
         pos_ff   <= pos_in;
         gi_ff    <= gi_in;
         phq_ff   <= phq_in;
         phr_ff   <= phr_in;
         sum_ff   <= sum_in;
         fin_ff   <= fin_in;
      end
   end

   // The position never runs past the end of a frame.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff < POS_W'(FRAME_BYTES))
      else $error("position counter out of range");

   // The phase remainder stays below the divisor.
   a_phase_rem: assert property (@(posedge clock) disable iff (reset)
      phr_ff < PHASE_R_W'(PHASE_DEN))
      else $error("phase remainder out of range");

   // A finished stream sits on its final byte position.
   a_fin_pos: assert property (@(posedge clock) disable iff (reset)
      fin_ff |-> (pos_ff == POS_W'(FRAME_BYTES - 1)) &&
                 (frame_ff == FRAME_W'(FRAME_COUNT - 1)))
      else $error("finished flag set away from the last byte");

   // Once finished, the stream holds still until a restart.
   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      fin_ff && !(ctrl.step && ctrl.restart) |=> $stable(lfsr_ff) && $stable(sum_ff))
      else $error("finished stream state moved without restart");

endmodule

[rtl/core/safg_out_reg.sv]
// Output holding register for generated items.
// Depends on safg_pkg.
module safg_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_valid,
   input  safg_pkg::result_type load_data,
   input  logic                 rsp_tready,
   output logic                 slot_free,
   output logic                 rsp_tvalid,
   output safg_pkg::result_type rsp_data
);
   import safg_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // The slot can take a new item when empty or being drained this cycle
   assign slot_free = !valid_ff || rsp_tready;
   assign valid_in  = slot_free ? load_valid : valid_ff;
   assign data_in   = (slot_free && load_valid) ? load_data : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_data   = data_ff;

endmodule

[rtl/core/synthetic_audio_frame_generator_core.sv]
// Top level of the synthetic audio frame generator: input register,
// generator engine and output register. Depends on safg_pkg, safg_engine, safg_out_reg.
//
//   Channel | Direction | Handshake          | Contents
//   req     | in        | tvalid/tready      | tdata[0] restart, [7:1] zero
//   rsp     | out       | tvalid/tready      | tdata byte, frame, position, checksum; tlast
//   csr     | in        | csr_wr_en          | csr_wr_data lfsr seed
//
// One item per clock when the result side keeps up; an accepted item is held in the input
// register, and its result is then held in the output register, which offers it on rsp.
// The LFSR step, byte select and checksum add all fit between those two registers.
// Synchronous active-high reset clears control state and loads the reset seed.
// A stall on rsp holds the output register; the input register then fills and
// req_tready drops. Items after the final byte are consumed with no result.
module synthetic_audio_frame_generator_core (
   input  logic                              clock,
   input  logic                              reset,
   // Input item channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [safg_pkg::REQ_DATA_W-1:0]   req_tdata,   // [0] restart, rest zero
   // Result item channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] data_byte, [16:8] frame_number, [22:17] byte_in_frame,
   // [54:23] running_checksum, [55] zero
   output logic [safg_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   // Seed register write
   input  logic                              csr_wr_en,
   input  logic [safg_pkg::LFSR_W-1:0]       csr_wr_data
);
   import safg_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic       in_restart_ff, in_restart_in;
   logic       accept;
   logic       slot_free;
   step_type   ctrl;
   logic       has_result;
   result_type gen_result;
   result_type out_result;

   // Input register: advances when the output slot can take the result
   assign req_tready    = !in_valid_ff || slot_free;
   assign accept        = req_tvalid && req_tready;
   assign in_valid_in   = accept ? 1'b1 : (slot_free ? 1'b0 : in_valid_ff);
   assign in_restart_in = accept ? req_tdata[0] : in_restart_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_restart_ff <= in_restart_in;
   end

   assign ctrl.step    = in_valid_ff && slot_free;
   assign ctrl.restart = in_restart_ff;

   // Generator engine
   safg_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .ctrl        (ctrl),
      .has_result  (has_result),
      .result      (gen_result)
   );

   // Output register
   safg_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load_valid (has_result),
      .load_data  (gen_result),
      .rsp_tready (rsp_tready),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_data   (out_result)
   );

   // Pack the result fields, first field lowest
   assign rsp_tdata = {{(RSP_DATA_W-RSP_BITS){1'b0}},
                       out_result.running_checksum,
                       out_result.byte_in_frame,
                       out_result.frame_number,
                       out_result.data_byte};
   assign rsp_tlast = out_result.last_byte;

endmodule
